FILE: hw/rtl/wslr_pkg.sv
// Shared constants, types and controller codes of the wide shaded line rasteriser.
`timescale 1ns / 1ps
package wslr_pkg;
  localparam int COORD_BITS = 12;
  localparam int MAX_STROKE = 16;
  localparam int CB = COORD_BITS;
  localparam int WB = $clog2(MAX_STROKE + 1);
  localparam int DW = CB + 3;
  localparam int NUM_BITS = 8 + CB;
  localparam int DCW = $clog2(NUM_BITS);
  localparam int IN_W = 104;
  localparam int OUT_W = 56;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [1:0] OCT_SHALLOW_UP = 2'd0;
  localparam logic [1:0] OCT_STEEP_UP = 2'd1;
  localparam logic [1:0] OCT_SHALLOW_DOWN = 2'd2;
  localparam logic [1:0] OCT_STEEP_DOWN = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIV,
    ST_EMIT,
    ST_ADV
  } state_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic div_step;
    logic k_inc;
    logic adv;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic div_last;
    logic w_zero;
    logic k_last;
  } sts_t;
endpackage

FILE: hw/rtl/wslr_ctrl.sv
// Sequencing controller of the line rasteriser.
`timescale 1ns / 1ps
module wslr_ctrl import wslr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_kind,
  input  logic out_tready,
  input  sts_t sts,
  output logic in_tready,
  output logic out_tvalid,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else if (sts.active) begin
            state_nxt = ST_PROD;
          end
        end
      end
      ST_PROD: begin
        cmd.prod = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = sts.w_zero ? ST_ADV : ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.k_last) begin
            state_nxt = ST_ADV;
          end else begin
            cmd.k_inc = 1'b1;
          end
        end
      end
      ST_ADV: begin
        cmd.adv = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

FILE: hw/rtl/wslr_dp.sv
// Line stepping, colour division and pixel datapath of the rasteriser.
`timescale 1ns / 1ps
module wslr_dp import wslr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic [OUT_W-1:0] out_data,
  output logic             col_last,
  output logic             line_done
);
  logic                active_r, active_nxt;
  logic [1:0]          oct_r, oct_nxt;
  logic [CB-1:0]       major_r, major_nxt;
  logic [CB-1:0]       minor_r, minor_nxt;
  logic [CB-1:0]       len_r, len_nxt;
  logic [CB-1:0]       span_r, span_nxt;
  logic signed [DW-1:0] dec_r, dec_nxt;
  logic [CB-1:0]       step_r, step_nxt;
  logic [WB-1:0]       width_r, width_nxt;
  logic [WB-1:0]       k_r;
  logic [DCW-1:0]      dcnt_r;
  logic [7:0]          cs_r [3];
  logic [7:0]          ce_r [3];
  logic [NUM_BITS-1:0] num_r [3];
  logic [CB-1:0]       rem_r [3];
  logic                neg_r [3];

  logic [CB-1:0] xs, ys, xe, ye, x0, y0, x1, y1, kx, aky;
  logic signed [CB:0] ky;
  logic [4:0] w_in;
  logic [7:0] cin_s [3];
  logic [7:0] cin_e [3];
  logic swap, shallow, last_col;
  logic [7:0] col [3];
  logic signed [13:0] off, px, py;

  assign xs = in_data[CB-1:0];
  assign ys = in_data[12+CB-1:12];
  assign xe = in_data[24+CB-1:24];
  assign ye = in_data[36+CB-1:36];
  assign w_in = in_data[52:48];
  assign cin_s[0] = in_data[60:53];
  assign cin_s[1] = in_data[68:61];
  assign cin_s[2] = in_data[76:69];
  assign cin_e[0] = in_data[84:77];
  assign cin_e[1] = in_data[92:85];
  assign cin_e[2] = in_data[100:93];

  assign swap = xs > xe;
  assign x0 = swap ? xe : xs;
  assign y0 = swap ? ye : ys;
  assign x1 = swap ? xs : xe;
  assign y1 = swap ? ys : ye;
  assign kx = x1 - x0;
  assign ky = $signed({1'b0, y1}) - $signed({1'b0, y0});
  assign aky = ky[CB] ? CB'(-ky) : ky[CB-1:0];
  assign shallow = kx >= aky;
  assign last_col = step_r >= len_r;

  always_comb begin
    active_nxt = active_r;
    oct_nxt = oct_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    len_nxt = len_r;
    span_nxt = span_r;
    dec_nxt = dec_r;
    step_nxt = step_r;
    width_nxt = width_r;
    if (cmd.load) begin
      oct_nxt = shallow ? (ky[CB] ? OCT_SHALLOW_DOWN : OCT_SHALLOW_UP)
                        : (ky[CB] ? OCT_STEEP_DOWN : OCT_STEEP_UP);
      major_nxt = shallow ? x0 : y0;
      minor_nxt = shallow ? y0 : x0;
      len_nxt = shallow ? kx : aky;
      span_nxt = shallow ? aky : kx;
      dec_nxt = $signed(DW'(len_nxt)) - $signed(DW'({span_nxt, 1'b0}));
      step_nxt = '0;
      width_nxt = (32'(w_in) > MAX_STROKE) ? WB'(MAX_STROKE) : WB'(w_in);
      active_nxt = 1'b1;
    end else if (cmd.adv) begin
      if (last_col) begin
        active_nxt = 1'b0;
      end else begin
        dec_nxt = dec_r;
        if (dec_r < 0) begin
          dec_nxt = dec_r + $signed(DW'({len_r, 1'b0}));
          minor_nxt = (oct_r == OCT_SHALLOW_DOWN) ? minor_r - 1'b1 : minor_r + 1'b1;
        end
        dec_nxt = dec_nxt - $signed(DW'({span_r, 1'b0}));
        major_nxt = (oct_r == OCT_STEEP_DOWN) ? major_r - 1'b1 : major_r + 1'b1;
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      oct_r <= '0;
      major_r <= '0;
      minor_r <= '0;
      len_r <= '0;
      span_r <= '0;
      dec_r <= '0;
      step_r <= '0;
      width_r <= '0;
    end else begin
      active_r <= active_nxt;
      oct_r <= oct_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      len_r <= len_nxt;
      span_r <= span_nxt;
      dec_r <= dec_nxt;
      step_r <= step_nxt;
      width_r <= width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    logic [8:0] diff;
    logic [7:0] mag;
    logic [CB:0] rsh;
    if (cmd.load) begin
      for (int c = 0; c < 3; c++) begin
        cs_r[c] <= swap ? cin_e[c] : cin_s[c];
        ce_r[c] <= swap ? cin_s[c] : cin_e[c];
      end
    end
    if (cmd.prod) begin
      dcnt_r <= '0;
      k_r <= '0;
      for (int c = 0; c < 3; c++) begin
        diff = {1'b0, ce_r[c]} - {1'b0, cs_r[c]};
        mag = diff[8] ? 8'(-diff) : diff[7:0];
        neg_r[c] <= diff[8];
        num_r[c] <= NUM_BITS'(mag) * NUM_BITS'(step_r);
        rem_r[c] <= '0;
      end
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      for (int c = 0; c < 3; c++) begin
        rsh = {rem_r[c], num_r[c][NUM_BITS-1]};
        if (rsh >= {1'b0, len_r}) begin
          rem_r[c] <= CB'(rsh - {1'b0, len_r});
          num_r[c] <= {num_r[c][NUM_BITS-2:0], 1'b1};
        end else begin
          rem_r[c] <= rsh[CB-1:0];
          num_r[c] <= {num_r[c][NUM_BITS-2:0], 1'b0};
        end
      end
    end else if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (len_r == '0) begin
        col[c] = cs_r[c];
      end else if (neg_r[c]) begin
        col[c] = cs_r[c] - num_r[c][7:0] - 8'(rem_r[c] != '0);
      end else begin
        col[c] = cs_r[c] + num_r[c][7:0];
      end
    end
  end

  assign off = $signed(14'(k_r)) - $signed(14'(width_r >> 1));
  assign px = (oct_r[0]) ? $signed(14'(minor_r)) + off : $signed(14'(major_r));
  assign py = (oct_r[0]) ? $signed(14'(major_r)) : $signed(14'(minor_r)) + off;
  assign out_data = {4'b0, col[2], col[1], col[0], py, px};
  assign col_last = (k_r == width_r - 1'b1);
  assign line_done = last_col;

  assign sts.active = active_r;
  assign sts.div_last = (dcnt_r == DCW'(NUM_BITS - 1));
  assign sts.w_zero = (width_r == '0);
  assign sts.k_last = col_last;
endmodule

FILE: hw/rtl/wide_shaded_line_rasterizer.sv
// Top level of the wide shaded line rasteriser.
`timescale 1ns / 1ps
// Usage:
//   in channel: in_tuser is the item kind (0 load a line, 1 step one column),
//   in_tdata carries the endpoints, stroke width and the two colours.
//   A load emits nothing; it replaces any line in progress.
//   A step on an active line emits stroke_width pixels (at most 16) on the
//   out channel, one per cycle while out_tready is high, out_tlast on the
//   last pixel of the column, out_tuser on every pixel of the final column.
//   A step with no active line is dropped. A step on an active line runs
//   a product state, then per-channel restoring dividers on a numerator of
//   8 + coordinate bits, then the pixels, then a midpoint decision advance.
//   The block works on one item at a time; in_tready is low meanwhile.
//   A stalled receiver holds the current pixel; the block waits.
//   Synchronous active-low reset clears the line state and the controller.
module wide_shaded_line_rasterizer import wslr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // x_start, y_start, x_end, y_end, stroke_width, red_start, green_start,
  // blue_start, red_end, green_end, blue_end, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  // kind
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // pixel_x, pixel_y, red, green, blue, zero pad
  output logic [OUT_W-1:0] out_tdata,
  // line_done
  output logic             out_tuser,
  output logic             out_tlast
);
  cmd_t cmd;
  sts_t sts;

  wslr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  wslr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_tdata),
    .col_last  (out_tlast),
    .line_done (out_tuser)
  );

`ifndef ASSERT_OFF
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input ready while a pixel is offered");
  a_col_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("pixel offered after column end");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> in_tready)
    else $error("load item did not return to idle");
`endif
endmodule
